// ----- rtl/core/irfd_pkg.sv -----
// Shared constants for the infrared remote frame decoder.
package irfd_pkg;

    // Default width of the decision and timeout countdown.
    localparam int unsigned COUNT_WIDTH_DEF = 8;

    localparam int unsigned REG_WIDTH  = 8;
    localparam int unsigned ADDR_WIDTH = 5;

    // Configuration register indexes (byte address = 4 * index).
    localparam logic [2:0] REG_ADDRESS_BYTE   = 3'd0;
    localparam logic [2:0] REG_REPEAT_CMD     = 3'd1;
    localparam logic [2:0] REG_BIT_DECISION   = 3'd2;
    localparam logic [2:0] REG_LEADER_CHECK   = 3'd3;
    localparam logic [2:0] REG_TIMEOUT        = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [REG_WIDTH-1:0] ADDRESS_BYTE_RST = 8'd0;
    localparam logic [REG_WIDTH-1:0] REPEAT_CMD_RST   = 8'd255;
    localparam logic [REG_WIDTH-1:0] BIT_DECISION_RST = 8'd53;
    localparam logic [REG_WIDTH-1:0] LEADER_CHECK_RST = 8'd141;
    localparam logic [REG_WIDTH-1:0] TIMEOUT_RST      = 8'd254;

    // Number of bits in one received byte.
    localparam int unsigned BYTE_BITS = 8;

endpackage

// ----- rtl/core/ir_remote_frame_decoder.sv -----
// Infrared remote frame decoder: edge timing, bit shifting and frame matching.
//
// Usage: feed one sample of the receiver level per timer tick on the slave
// stream (s_tdata bit 0 = ir_on). Every accepted word yields exactly one
// result word on the master stream: command_valid, command and activity.
// A rising edge before bit_decision_ticks shifts in a 1; expiry of that time
// shifts in a 0 and starts a timeout of timeout_ticks, whose expiry flushes
// the partial byte and ends the frame. A byte equal to address_byte starts a
// frame, the next byte is skipped and the one after is reported as the
// command; after it, every zero byte but the first reports the repeat command.
// The result word is registered at the edge that accepts its sample.
// Throughput: one word per cycle while the result stream is not stalled; the whole
// step is one pass of logic between the accepting edge and the result register.
// Stall: when the result register is full and m_tready is low, s_tready drops
// and the block holds its state until the result is taken.
// Reset (aresetn low, synchronous): all decoder state clears, the registers
// take their reset values and the result register empties.
// Configuration: APB writes at byte address 4*index; write only while idle.
module ir_remote_frame_decoder #(
    parameter int unsigned COUNT_WIDTH = irfd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Sample stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] ir_on, [7:1] zero
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [0] command_valid,
                                                      // [8:1] command,
                                                      // [9] activity, [15:10] zero
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [irfd_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int unsigned CW = COUNT_WIDTH;
    // Common width for comparing a register value against the count limit.
    localparam int unsigned SW = (CW > irfd_pkg::REG_WIDTH) ? CW : irfd_pkg::REG_WIDTH;
    localparam logic [SW-1:0] COUNT_MAX = SW'((64'd1 << CW) - 64'd1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MAYBE_LEADER,
        PH_LEADER_OK,
        PH_FIRST_BIT,
        PH_ACTIVE,
        PH_TIMING_OUT
    } proto_phase_t;

    typedef enum logic [2:0] {
        FR_NO_MATCH,
        FR_FOUND_ADDR,
        FR_SIGNIFICANT,
        FR_WAIT_END,
        FR_WAIT_REPEAT
    } frame_phase_t;

    // Configuration registers
    logic [7:0] address_byte_reg;
    logic [7:0] repeat_cmd_reg;
    logic [7:0] bit_decision_reg;
    logic [7:0] leader_check_reg;
    logic [7:0] timeout_reg;

    // Decoder state
    logic          prev_level_reg,  prev_level_next;
    proto_phase_t  proto_phase_reg, proto_phase_next;
    frame_phase_t  frame_phase_reg, frame_phase_next;
    logic [7:0]    shift_byte_reg,  shift_byte_next;
    logic [2:0]    bit_count_reg,   bit_count_next;
    logic [CW-1:0] countdown_reg,   countdown_next;
    logic          timer_armed_reg, timer_armed_next;
    logic          expiry_pend_reg, expiry_pend_next;

    // Result register
    logic       m_tvalid_reg;
    logic       cmd_valid_reg, cmd_valid_next;
    logic [7:0] command_reg,   command_next;
    logic       activity_reg,  activity_next;

    logic       ir_on;
    logic       edge_seen;
    logic       accept;
    logic       cfg_write;
    logic [2:0] cfg_index;

    // Arming values, saturated to the countdown width
    logic [CW-1:0] leader_load;
    logic [CW-1:0] decision_load;
    logic [CW-1:0] timeout_load;

    function automatic logic [CW-1:0] sat_load(input logic [7:0] ticks);
        logic [SW-1:0] wide;
        wide = SW'(ticks);
        if (wide > COUNT_MAX) begin
            wide = COUNT_MAX;
        end
        return wide[CW-1:0];
    endfunction

    assign leader_load   = sat_load(leader_check_reg);
    assign decision_load = sat_load(bit_decision_reg);
    assign timeout_load  = sat_load(timeout_reg);

    assign ir_on     = s_tdata[0];
    assign edge_seen = ir_on != prev_level_reg;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, activity_reg, command_reg, cmd_valid_reg};

    // Configuration access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_comb begin
        unique case (cfg_index)
            irfd_pkg::REG_ADDRESS_BYTE: prdata = {24'd0, address_byte_reg};
            irfd_pkg::REG_REPEAT_CMD:   prdata = {24'd0, repeat_cmd_reg};
            irfd_pkg::REG_BIT_DECISION: prdata = {24'd0, bit_decision_reg};
            irfd_pkg::REG_LEADER_CHECK: prdata = {24'd0, leader_check_reg};
            irfd_pkg::REG_TIMEOUT:      prdata = {24'd0, timeout_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // One decoder step per accepted sample
    always_comb begin
        logic       shift_req;
        logic       shift_bit;
        logic       flush_req;
        logic [7:0] flush_val;
        logic [7:0] shifted;

        prev_level_next  = ir_on;
        proto_phase_next = proto_phase_reg;
        frame_phase_next = frame_phase_reg;
        shift_byte_next  = shift_byte_reg;
        bit_count_next   = bit_count_reg;
        countdown_next   = countdown_reg;
        timer_armed_next = timer_armed_reg;
        expiry_pend_next = expiry_pend_reg;
        cmd_valid_next   = 1'b0;
        command_next     = 8'd0;
        activity_next    = edge_seen;
        shift_req        = 1'b0;
        shift_bit        = 1'b0;
        flush_req        = 1'b0;
        flush_val        = 8'd0;
        shifted          = 8'd0;

        // Advance the one-shot timer
        if (timer_armed_reg) begin
            if (countdown_reg <= CW'(1)) begin
                countdown_next   = '0;
                timer_armed_next = 1'b0;
                expiry_pend_next = 1'b1;
            end else begin
                countdown_next = countdown_reg - CW'(1);
            end
        end

        if (edge_seen) begin
            unique case (proto_phase_reg)
                PH_IDLE: begin
                    if (ir_on) begin
                        countdown_next   = leader_load;
                        timer_armed_next = 1'b1;
                        proto_phase_next = PH_MAYBE_LEADER;
                    end
                end
                PH_MAYBE_LEADER: proto_phase_next = PH_IDLE;
                PH_LEADER_OK: begin
                    if (!ir_on) begin
                        proto_phase_next = PH_FIRST_BIT;
                    end
                end
                PH_FIRST_BIT, PH_TIMING_OUT: begin
                    if (ir_on) begin
                        proto_phase_next = PH_ACTIVE;
                        countdown_next   = decision_load;
                        timer_armed_next = 1'b1;
                    end
                end
                PH_ACTIVE: begin
                    if (ir_on) begin
                        shift_req        = 1'b1;
                        shift_bit        = 1'b1;
                        countdown_next   = decision_load;
                        timer_armed_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end else if (expiry_pend_next) begin
            // Service an expiry, possibly held over from an edge tick
            expiry_pend_next = 1'b0;
            unique case (proto_phase_reg)
                PH_MAYBE_LEADER: begin
                    if (ir_on) begin
                        proto_phase_next = PH_LEADER_OK;
                    end
                    timer_armed_next = 1'b0;
                end
                PH_ACTIVE: begin
                    shift_req        = 1'b1;
                    shift_bit        = 1'b0;
                    proto_phase_next = PH_TIMING_OUT;
                    countdown_next   = timeout_load;
                    timer_armed_next = 1'b1;
                end
                PH_TIMING_OUT: begin
                    proto_phase_next = PH_IDLE;
                    flush_req        = 1'b1;
                    flush_val        = shift_byte_reg;
                    timer_armed_next = 1'b0;
                end
                default: timer_armed_next = 1'b0;
            endcase
        end

        // Shift a bit in; a full byte goes to the frame matcher
        if (shift_req) begin
            shifted = {shift_byte_reg[6:0], shift_bit};
            if (bit_count_reg == 3'(irfd_pkg::BYTE_BITS - 1)) begin
                flush_req = 1'b1;
                flush_val = shifted;
            end else begin
                shift_byte_next = shifted;
                bit_count_next  = bit_count_reg + 3'd1;
            end
        end

        // Frame matching on each flushed byte; the address check comes first
        if (flush_req) begin
            shift_byte_next = 8'd0;
            bit_count_next  = 3'd0;
            if (flush_val == address_byte_reg) begin
                frame_phase_next = FR_FOUND_ADDR;
            end else begin
                unique case (frame_phase_reg)
                    FR_FOUND_ADDR: frame_phase_next = FR_SIGNIFICANT;
                    FR_SIGNIFICANT: begin
                        cmd_valid_next   = 1'b1;
                        command_next     = flush_val;
                        frame_phase_next = FR_WAIT_END;
                    end
                    FR_WAIT_END: begin
                        if (flush_val == 8'd0) begin
                            frame_phase_next = FR_WAIT_REPEAT;
                        end
                    end
                    FR_WAIT_REPEAT: begin
                        if (flush_val == 8'd0) begin
                            cmd_valid_next = 1'b1;
                            command_next   = repeat_cmd_reg;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            address_byte_reg <= irfd_pkg::ADDRESS_BYTE_RST;
            repeat_cmd_reg   <= irfd_pkg::REPEAT_CMD_RST;
            bit_decision_reg <= irfd_pkg::BIT_DECISION_RST;
            leader_check_reg <= irfd_pkg::LEADER_CHECK_RST;
            timeout_reg      <= irfd_pkg::TIMEOUT_RST;
            prev_level_reg   <= 1'b0;
            proto_phase_reg  <= PH_IDLE;
            frame_phase_reg  <= FR_NO_MATCH;
            shift_byte_reg   <= 8'd0;
            bit_count_reg    <= 3'd0;
            countdown_reg    <= '0;
            timer_armed_reg  <= 1'b0;
            expiry_pend_reg  <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    irfd_pkg::REG_ADDRESS_BYTE: address_byte_reg <= pwdata[7:0];
                    irfd_pkg::REG_REPEAT_CMD:   repeat_cmd_reg   <= pwdata[7:0];
                    irfd_pkg::REG_BIT_DECISION: bit_decision_reg <= pwdata[7:0];
                    irfd_pkg::REG_LEADER_CHECK: leader_check_reg <= pwdata[7:0];
                    irfd_pkg::REG_TIMEOUT:      timeout_reg      <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (accept) begin
                prev_level_reg  <= prev_level_next;
                proto_phase_reg <= proto_phase_next;
                frame_phase_reg <= frame_phase_next;
                shift_byte_reg  <= shift_byte_next;
                bit_count_reg   <= bit_count_next;
                countdown_reg   <= countdown_next;
                timer_armed_reg <= timer_armed_next;
                expiry_pend_reg <= expiry_pend_next;
                m_tvalid_reg    <= 1'b1;
                // Load the result payload with the word
                cmd_valid_reg   <= cmd_valid_next;
                command_reg     <= command_next;
                activity_reg    <= activity_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule
